@@ hw/rtl/assert_macros.svh @@
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_AT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed: lbl");
`define ASSERT_NEVER(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("assertion failed: lbl");
`else
`define ASSERT_AT(lbl, clk, rst, prop)
`define ASSERT_NEVER(lbl, clk, rst, expr)
`endif
`endif

@@ hw/rtl/i2cmb_pkg.sv @@
// types, constants and the phase program table of the i2c bit engine
package i2cmb_pkg;

   typedef enum logic [2:0] {
      CMD_NONE  = 3'd0,
      CMD_INIT  = 3'd1,
      CMD_START = 3'd2,
      CMD_STOP  = 3'd3,
      CMD_WRITE = 3'd4,
      CMD_READ  = 3'd5,
      CMD_WAIT  = 3'd6,
      CMD_ACK   = 3'd7
   } cmd_type;

   // classified request as it travels through the queue
   typedef struct packed {
      cmd_type    cmd;
      logic       has_cmd;
      logic [7:0] write_data;
      logic       send_ack;
      logic       sda_in;
   } item_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // configuration register indexes
   localparam logic CSR_PHASE_TICKS = 1'b0;
   localparam logic CSR_ACK_TIMEOUT = 1'b1;

   localparam logic [15:0] PHASE_TICKS_RST = 16'd1;
   localparam logic [7:0]  ACK_TIMEOUT_RST = 8'd250;
   localparam logic [3:0]  LAST_BIT        = 4'd7;

   // result bit positions
   localparam int RSP_BUSY_BIT = 3;
   localparam int RSP_DONE_BIT = 4;

   // phase operations
   localparam logic [3:0] OP_END    = 4'd0;
   localparam logic [3:0] OP_DRV0   = 4'd1;
   localparam logic [3:0] OP_DRV1   = 4'd2;
   localparam logic [3:0] OP_SCL0   = 4'd3;
   localparam logic [3:0] OP_SCL1   = 4'd4;
   localparam logic [3:0] OP_SDA0   = 4'd5;
   localparam logic [3:0] OP_SDA1   = 4'd6;
   localparam logic [3:0] OP_BIT    = 4'd7;
   localparam logic [3:0] OP_HOLD   = 4'd8;
   localparam logic [3:0] OP_SAMPLE = 4'd9;
   localparam logic [3:0] OP_ACK    = 4'd10;
   localparam logic [3:0] OP_POLL   = 4'd11;
   localparam logic [3:0] OP_LOOP   = 4'd12;

   // table entries: low nibble op, high nibble loop target step
   localparam logic [7:0] E_END    = {4'd0, OP_END};
   localparam logic [7:0] E_DRV0   = {4'd0, OP_DRV0};
   localparam logic [7:0] E_DRV1   = {4'd0, OP_DRV1};
   localparam logic [7:0] E_SCL0   = {4'd0, OP_SCL0};
   localparam logic [7:0] E_SCL1   = {4'd0, OP_SCL1};
   localparam logic [7:0] E_SDA0   = {4'd0, OP_SDA0};
   localparam logic [7:0] E_SDA1   = {4'd0, OP_SDA1};
   localparam logic [7:0] E_BIT    = {4'd0, OP_BIT};
   localparam logic [7:0] E_HOLD   = {4'd0, OP_HOLD};
   localparam logic [7:0] E_SAMPLE = {4'd0, OP_SAMPLE};
   localparam logic [7:0] E_ACK    = {4'd0, OP_ACK};
   localparam logic [7:0] E_POLL   = {4'd0, OP_POLL};
   localparam logic [7:0] E_LOOP3  = {4'd3, OP_LOOP};
   localparam logic [7:0] E_LOOP2  = {4'd2, OP_LOOP};

   localparam logic [7:0] PROG [8][16] = '{
      '{E_END, E_END, E_END, E_END, E_END, E_END, E_END, E_END,
        E_END, E_END, E_END, E_END, E_END, E_END, E_END, E_END},
      '{E_DRV1, E_HOLD, E_SCL1, E_SDA1, E_END, E_END, E_END, E_END,
        E_END, E_END, E_END, E_END, E_END, E_END, E_END, E_END},
      '{E_DRV1, E_SDA1, E_SCL1, E_SDA0, E_SCL0, E_END, E_END, E_END,
        E_END, E_END, E_END, E_END, E_END, E_END, E_END, E_END},
      '{E_DRV1, E_SCL0, E_SDA0, E_SCL1, E_SDA1, E_END, E_END, E_END,
        E_END, E_END, E_END, E_END, E_END, E_END, E_END, E_END},
      '{E_DRV1, E_SCL0, E_BIT, E_HOLD, E_SCL1, E_SCL0, E_LOOP3, E_END,
        E_END, E_END, E_END, E_END, E_END, E_END, E_END, E_END},
      '{E_DRV0, E_SCL0, E_SCL1, E_SAMPLE, E_LOOP2, E_SCL0, E_DRV1, E_ACK,
        E_SCL1, E_SCL0, E_END, E_END, E_END, E_END, E_END, E_END},
      '{E_DRV0, E_SDA1, E_SCL1, E_POLL, E_SCL0, E_END, E_END, E_END,
        E_END, E_END, E_END, E_END, E_END, E_END, E_END, E_END},
      '{E_SCL0, E_DRV1, E_ACK, E_SCL1, E_SCL0, E_END, E_END, E_END,
        E_END, E_END, E_END, E_END, E_END, E_END, E_END, E_END}
   };

   function automatic logic [7:0] op_at(input cmd_type c, input logic [4:0] step);
      logic [4:0] idx;
      idx = step - 5'd1;
      if (step == 5'd0 || step > 5'd16) begin
         return E_END;
      end
      return PROG[c][idx[3:0]];
   endfunction

endpackage

@@ hw/rtl/i2c_master_bit_engine.sv @@
// top level of the i2c master bit engine: front stage, queue and pin sequencer
//
//   channel   ports             payload
//   request   req_t*            cmd, write_data, send_ack, sda_in (one tick each)
//   result    rsp_t*            scl, sda, drive, busy, done, read_data, ack_missing
//   config    csr_we/addr/wdata phase_ticks (0), ack_timeout (1)
//
// one request transaction per clock in steady state unless the result side stalls; a
// result passes the front register, the queue slot and the sequencer output register.
// the sequencer does a whole tick combinationally: program lookup, phase count, loop.
// reset is synchronous; bus pins come out released with the output driver on.
// a four-entry queue lets the request side keep going while the result side stalls.
module i2c_master_bit_engine (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // cmd[2:0], write_data[10:3], send_ack[11], sda_in[12], zero pad
   input  logic [15:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // scl_level[0], sda_level[1], sda_drive[2], busy_res[3], done_res[4],
   // read_data[12:5], ack_missing[13], zero pad
   output logic [15:0] rsp_tdata,
   input  logic        csr_we,
   input  logic        csr_addr,
   input  logic [15:0] csr_wdata
);
   import i2cmb_pkg::*;
   `include "assert_macros.svh"

   q_status_type q_stat;
   item_type     push_item;
   item_type     head_item;
   logic         q_push;
   logic         q_pop;
   logic         rsp_done_busy;

   i2cmb_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .q_stat     (q_stat),
      .q_push     (q_push),
      .q_item     (push_item)
   );

   i2cmb_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (push_item),
      .pop       (q_pop),
      .head_item (head_item),
      .stat      (q_stat)
   );

   i2cmb_back u_back (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .head_item  (head_item),
      .q_stat     (q_stat),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   assign rsp_done_busy = rsp_tdata[RSP_DONE_BIT] && rsp_tdata[RSP_BUSY_BIT];

   `ASSERT_NEVER(a_queue_overflow, clock, reset, q_push && q_stat.full)
   `ASSERT_NEVER(a_queue_underflow, clock, reset, q_pop && q_stat.empty)
   `ASSERT_NEVER(a_done_not_busy, clock, reset, rsp_tvalid && rsp_done_busy)

endmodule

@@ hw/rtl/i2cmb_front.sv @@
// front stage: takes request transactions and classifies the command
module i2cmb_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // cmd[2:0], write_data[10:3], send_ack[11], sda_in[12], zero pad
   input  logic [15:0]            req_tdata,
   input  i2cmb_pkg::q_status_type q_stat,
   output logic                   q_push,
   output i2cmb_pkg::item_type    q_item
);
   import i2cmb_pkg::*;

   logic     valid_ff, valid_in;
   item_type item_ff, item_in;
   logic     take;

   assign req_tready = !valid_ff || !q_stat.full;
   assign take       = req_tvalid && req_tready;
   assign q_push     = valid_ff && !q_stat.full;
   assign q_item     = item_ff;

   always_comb begin
      item_in            = item_ff;
      valid_in           = take || (valid_ff && !q_push);
      if (take) begin
         item_in.cmd        = cmd_type'(req_tdata[2:0]);
         item_in.has_cmd    = (cmd_type'(req_tdata[2:0]) != CMD_NONE);
         item_in.write_data = req_tdata[10:3];
         item_in.send_ack   = req_tdata[11];
         item_in.sda_in     = req_tdata[12];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

endmodule

@@ hw/rtl/i2cmb_queue.sv @@
// short queue between the front stage and the pin sequencer
module i2cmb_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  i2cmb_pkg::item_type     push_item,
   input  logic                    pop,
   output i2cmb_pkg::item_type     head_item,
   output i2cmb_pkg::q_status_type stat
);
   import i2cmb_pkg::*;

   item_type            slots_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;

   assign stat.full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign stat.empty = (count_ff == '0);
   assign head_item  = slots_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

@@ hw/rtl/i2cmb_back.sv @@
// pin sequencer: runs one tick per queued item while a command is active and registers the result
module i2cmb_back (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_we,
   input  logic                    csr_addr,
   input  logic [15:0]             csr_wdata,
   input  i2cmb_pkg::item_type     head_item,
   input  i2cmb_pkg::q_status_type q_stat,
   output logic                    q_pop,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   // scl_level[0], sda_level[1], sda_drive[2], busy_res[3], done_res[4],
   // read_data[12:5], ack_missing[13], zero pad
   output logic [15:0]             rsp_tdata
);
   import i2cmb_pkg::*;

   logic [15:0] phase_ticks_ff;
   logic [7:0]  ack_timeout_ff;

   logic [4:0]  step_ff, step_in;
   cmd_type     acmd_ff, acmd_in;
   logic [3:0]  bitc_ff, bitc_in;
   logic [7:0]  shift_ff, shift_in;
   logic [15:0] pc_ff, pc_in;
   logic [7:0]  tc_ff, tc_in;
   logic        ackc_ff, ackc_in;
   logic        scl_ff, scl_in;
   logic        sda_ff, sda_in;
   logic        drv_ff, drv_in;
   logic        err_ff, err_in;
   logic [7:0]  last_ff, last_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [15:0] rsp_data_ff, rsp_data_in;

   logic        done_v;
   logic        run_v;
   logic [7:0]  op_v;

   assign q_pop      = !q_stat.empty && (!rsp_valid_ff || rsp_tready);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_comb begin
      step_in  = step_ff;
      acmd_in  = acmd_ff;
      bitc_in  = bitc_ff;
      shift_in = shift_ff;
      pc_in    = pc_ff;
      tc_in    = tc_ff;
      ackc_in  = ackc_ff;
      scl_in   = scl_ff;
      sda_in   = sda_ff;
      drv_in   = drv_ff;
      err_in   = err_ff;
      last_in  = last_ff;
      done_v   = 1'b0;
      run_v    = 1'b1;
      op_v     = E_END;

      if (q_pop) begin
         // a command is taken only while idle
         if (step_in == 5'd0 && head_item.has_cmd) begin
            acmd_in  = head_item.cmd;
            shift_in = head_item.write_data;
            ackc_in  = head_item.send_ack;
            bitc_in  = 4'd0;
            tc_in    = 8'd0;
            err_in   = 1'b0;
            pc_in    = 16'd0;
            step_in  = 5'd1;
         end
         if (step_in != 5'd0) begin
            op_v = op_at(acmd_in, step_in);
            if (op_v[3:0] == OP_POLL) begin
               if (!head_item.sda_in) begin
                  step_in = step_in + 5'd1;
                  pc_in   = 16'd0;
               end else if (({1'b0, tc_in} + 9'd1) > {1'b0, ack_timeout_ff}) begin
                  // no acknowledge: fall into the stop sequence
                  err_in  = 1'b1;
                  acmd_in = CMD_STOP;
                  step_in = 5'd1;
                  pc_in   = 16'd0;
               end else begin
                  tc_in = tc_in + 8'd1;
                  run_v = 1'b0;
               end
            end
            if (run_v) begin
               if (pc_in == 16'd0) begin
                  op_v = op_at(acmd_in, step_in);
                  case (op_v[3:0])
                     OP_DRV0: drv_in = 1'b0;
                     OP_DRV1: drv_in = 1'b1;
                     OP_SCL0: scl_in = 1'b0;
                     OP_SCL1: scl_in = 1'b1;
                     OP_SDA0: sda_in = 1'b0;
                     OP_SDA1: sda_in = 1'b1;
                     OP_BIT: begin
                        sda_in   = shift_in[7];
                        shift_in = {shift_in[6:0], 1'b0};
                     end
                     OP_SAMPLE: shift_in = {shift_in[6:0], head_item.sda_in};
                     OP_ACK:    sda_in = !ackc_in;
                     default: ;
                  endcase
                  pc_in = (phase_ticks_ff == 16'd0) ? 16'd1 : phase_ticks_ff;
               end
               pc_in = pc_in - 16'd1;
               if (pc_in == 16'd0) begin
                  step_in = step_in + 5'd1;
                  op_v    = op_at(acmd_in, step_in);
                  // a loop entry never lands on another loop entry
                  if (op_v[3:0] == OP_LOOP) begin
                     if (bitc_in < LAST_BIT) begin
                        bitc_in = bitc_in + 4'd1;
                        step_in = {1'b0, op_v[7:4]};
                     end else begin
                        step_in = step_in + 5'd1;
                     end
                     op_v = op_at(acmd_in, step_in);
                  end
                  if (op_v[3:0] == OP_END) begin
                     if (acmd_in == CMD_READ) begin
                        last_in = shift_in;
                     end
                     done_v  = 1'b1;
                     step_in = 5'd0;
                  end
               end
            end
         end
      end

      rsp_valid_in = q_pop || (rsp_valid_ff && !rsp_tready);
      rsp_data_in  = rsp_data_ff;
      if (q_pop) begin
         rsp_data_in = {2'b00, err_in, last_in, done_v, (step_in != 5'd0),
                        drv_in, sda_in, scl_in};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ticks_ff <= PHASE_TICKS_RST;
         ack_timeout_ff <= ACK_TIMEOUT_RST;
         step_ff        <= 5'd0;
         acmd_ff        <= CMD_NONE;
         bitc_ff        <= 4'd0;
         shift_ff       <= 8'd0;
         pc_ff          <= 16'd0;
         tc_ff          <= 8'd0;
         ackc_ff        <= 1'b0;
         scl_ff         <= 1'b1;
         sda_ff         <= 1'b1;
         drv_ff         <= 1'b1;
         err_ff         <= 1'b0;
         last_ff        <= 8'd0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_we && csr_addr == CSR_PHASE_TICKS) begin
            phase_ticks_ff <= csr_wdata;
         end
         if (csr_we && csr_addr == CSR_ACK_TIMEOUT) begin
            ack_timeout_ff <= csr_wdata[7:0];
         end
         step_ff      <= step_in;
         acmd_ff      <= acmd_in;
         bitc_ff      <= bitc_in;
         shift_ff     <= shift_in;
         pc_ff        <= pc_in;
         tc_ff        <= tc_in;
         ackc_ff      <= ackc_in;
         scl_ff       <= scl_in;
         sda_ff       <= sda_in;
         drv_ff       <= drv_in;
         err_ff       <= err_in;
         last_ff      <= last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

endmodule
